>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the rtl, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define BSWS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// consequent checked in the cycle after the antecedent
`define BSWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSWS_ASSERT(label, prop, msg)
`define BSWS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/bsws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_pkg
// shared constants, codes and types of the bounded stack with search
// ----------------------------------------------------------------------------
package bsws_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int POS_W          = 6;
    localparam int CAP_W          = 7;
    localparam int OP_W           = 3;
    localparam int ST_W           = 3;
    localparam int TDATA_W        = 40;
    localparam int Q_DEPTH        = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_READ   = 3'd2,
        OP_SEARCH = 3'd3,
        OP_SHOW   = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [FIELD_W-1:0] data;
        logic [POS_W-1:0]   pos;
    } t_cmd;

    typedef struct packed {
        logic             busy;
        logic [CAP_W-1:0] count;
    } t_bk_stat;

endpackage

>>> rtl/bsws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_front
// takes requests, decodes the opcode and drops codes with no meaning
// ----------------------------------------------------------------------------
module bsws_front (
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [bsws_pkg::OP_W-1:0]       i_opcode,
    input  logic [bsws_pkg::FIELD_W-1:0]    i_data,
    input  logic [bsws_pkg::POS_W-1:0]      i_pos,
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_ready,
    output bsws_pkg::t_cmd                  o_cmd
);
    import bsws_pkg::*;

    logic w_legal;

    always_comb begin
        unique case (i_opcode)
            OP_PUSH, OP_POP, OP_READ, OP_SEARCH, OP_SHOW: w_legal = 1'b1;
            default: w_legal = 1'b0;
        endcase
    end

    // illegal requests are taken and discarded
    assign o_in_ready  = i_cmd_ready;
    assign o_cmd_valid = i_in_valid && w_legal;
    assign o_cmd.op    = t_op'(i_opcode);
    assign o_cmd.data  = i_data;
    assign o_cmd.pos   = i_pos;

endmodule

>>> rtl/bsws_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module bsws_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bsws_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output bsws_pkg::t_cmd  o_cmd
);
    import bsws_pkg::*;

    localparam int QA = $clog2(Q_DEPTH);
    localparam int QF = $clog2(Q_DEPTH + 1);

    t_cmd            r_slot [Q_DEPTH];
    logic [QA-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QA-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QF-1:0]   r_fill, n_fill;
    logic            w_push, w_pop;

    assign o_ready = (r_fill != QF'(Q_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = w_push ? QA'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? QA'(r_rd_ptr + 1'b1) : r_rd_ptr;
        unique case ({w_push, w_pop})
            2'b10:   n_fill = QF'(r_fill + 1'b1);
            2'b01:   n_fill = QF'(r_fill - 1'b1);
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/bsws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_back
// executes stack commands against the entry memory and drives results
// ----------------------------------------------------------------------------
module bsws_back #(
    parameter int DEPTH      = bsws_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bsws_pkg::DATA_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [bsws_pkg::CAP_W-1:0]      i_cap,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_ready,
    input  bsws_pkg::t_cmd                  i_cmd,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bsws_pkg::t_status               o_status,
    output logic [bsws_pkg::FIELD_W-1:0]    o_value,
    output logic [bsws_pkg::POS_W-1:0]      o_pos,
    output logic                            o_last,
    output bsws_pkg::t_bk_stat              o_stat
);
    import bsws_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_ONE    = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FLUSH  = 5'b10000
    } t_state;

    t_state                  r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_idx, n_idx;
    logic                    r_found, n_found;
    logic [DATA_WIDTH-1:0]   r_pend_val, n_pend_val;
    logic [AW-1:0]           r_pend_idx, n_pend_idx;

    logic [DATA_WIDTH-1:0]   r_mem [DEPTH];
    logic [DATA_WIDTH-1:0]   r_rd_data;
    logic                    wr_en, rd_en;
    logic [AW-1:0]           rd_addr;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [FIELD_W-1:0]      r_out_value;
    logic [POS_W-1:0]        r_out_pos;
    logic                    r_out_last;

    logic                    emit, step, out_free, full, bad_pos, match;
    t_status                 e_status;
    logic [FIELD_W-1:0]      e_value;
    logic [POS_W-1:0]        e_pos;
    logic                    e_last;
    logic [AW-1:0]           count_m1;
    logic [DATA_WIDTH-1:0]   key;
    logic [FIELD_W-1:0]      key_field, rd_field, pend_field;

    // stored form is the input sign-extended or cut to the data width
    generate
        if (DATA_WIDTH > FIELD_W) begin : g_key_wide
            assign key = {{(DATA_WIDTH - FIELD_W){r_cmd.data[FIELD_W-1]}}, r_cmd.data};
        end else begin : g_key_narrow
            assign key = r_cmd.data[DATA_WIDTH-1:0];
        end
        if (DATA_WIDTH >= FIELD_W) begin : g_fld_wide
            assign key_field  = key[FIELD_W-1:0];
            assign rd_field   = r_rd_data[FIELD_W-1:0];
            assign pend_field = r_pend_val[FIELD_W-1:0];
        end else begin : g_fld_narrow
            assign key_field  = {{(FIELD_W - DATA_WIDTH){key[DATA_WIDTH-1]}}, key};
            assign rd_field   = {{(FIELD_W - DATA_WIDTH){r_rd_data[DATA_WIDTH-1]}}, r_rd_data};
            assign pend_field = {{(FIELD_W - DATA_WIDTH){r_pend_val[DATA_WIDTH-1]}},
                                 r_pend_val};
        end
    endgenerate

    assign out_free = !r_out_valid || i_out_ready;
    assign full     = (CAP_W'(r_count) >= i_cap) || (r_count == CW'(DEPTH));
    assign bad_pos  = (CAP_W'(r_cmd.pos) >= CAP_W'(r_count));
    assign count_m1 = AW'(r_count - 1'b1);
    assign match    = (r_rd_data == key);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_count    = r_count;
        n_idx      = r_idx;
        n_found    = r_found;
        n_pend_val = r_pend_val;
        n_pend_idx = r_pend_idx;
        o_cmd_ready = 1'b0;
        emit       = 1'b0;
        step       = 1'b0;
        e_status   = ST_OK;
        e_value    = '0;
        e_pos      = '0;
        e_last     = 1'b1;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_idx;

        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (r_cmd.op)
                    OP_PUSH: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (full) begin
                                e_status = ST_FULL;
                                e_value  = r_cmd.data;
                            end else begin
                                wr_en   = 1'b1;
                                e_value = key_field;
                                e_pos   = POS_W'(r_count);
                                n_count = CW'(r_count + 1'b1);
                            end
                        end
                    end
                    OP_POP: begin
                        if (r_count == '0) begin
                            if (out_free) begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                                n_state  = S_IDLE;
                            end
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = count_m1;
                            n_idx   = count_m1;
                            n_state = S_ONE;
                        end
                    end
                    OP_READ: begin
                        if (bad_pos) begin
                            if (out_free) begin
                                emit     = 1'b1;
                                e_status = ST_BADPOS;
                                e_pos    = r_cmd.pos;
                                n_state  = S_IDLE;
                            end
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_cmd.pos[AW-1:0];
                            n_idx   = r_cmd.pos[AW-1:0];
                            n_state = S_ONE;
                        end
                    end
                    OP_SEARCH, OP_SHOW: begin
                        if (r_count == '0) begin
                            if (out_free) begin
                                emit    = 1'b1;
                                n_state = S_IDLE;
                                if (r_cmd.op == OP_SEARCH) begin
                                    e_status = ST_NOTFOUND;
                                    e_value  = r_cmd.data;
                                end else begin
                                    e_status = ST_EMPTY;
                                end
                            end
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = count_m1;
                            n_idx   = count_m1;
                            n_found = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_ONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_value = rd_field;
                    e_pos   = POS_W'(r_idx);
                    n_state = S_IDLE;
                    if (r_cmd.op == OP_POP) begin
                        n_count = CW'(r_idx);
                    end
                end
            end
            S_SCAN: begin
                if (r_cmd.op == OP_SHOW) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_value = rd_field;
                        e_pos   = POS_W'(r_idx);
                        e_last  = (r_idx == '0);
                        step    = 1'b1;
                    end
                end else begin
                    // a held match goes out only once a later one proves it is not last
                    if (match && r_found) begin
                        if (out_free) begin
                            emit    = 1'b1;
                            e_value = pend_field;
                            e_pos   = POS_W'(r_pend_idx);
                            e_last  = 1'b0;
                            step    = 1'b1;
                        end
                    end else begin
                        step = 1'b1;
                    end
                    if (step && match) begin
                        n_found    = 1'b1;
                        n_pend_val = r_rd_data;
                        n_pend_idx = r_idx;
                    end
                end
                if (step) begin
                    if (r_idx == '0) begin
                        n_state = (r_cmd.op == OP_SHOW) ? S_IDLE : S_FLUSH;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(r_idx - 1'b1);
                        n_idx   = AW'(r_idx - 1'b1);
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_found) begin
                        e_value = pend_field;
                        e_pos   = POS_W'(r_pend_idx);
                    end else begin
                        e_status = ST_NOTFOUND;
                        e_value  = r_cmd.data;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_pend_val <= n_pend_val;
        r_pend_idx <= n_pend_idx;
        if (emit) begin
            r_out_status <= e_status;
            r_out_value  <= e_value;
            r_out_pos    <= e_pos;
            r_out_last   <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= key;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_value      = r_out_value;
    assign o_pos        = r_out_pos;
    assign o_last       = r_out_last;
    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.count = CAP_W'(r_count);

endmodule

>>> rtl/bounded_stack_with_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top
// bounded lifo stack of signed words with position read and value search
// ----------------------------------------------------------------------------
// requests come in on s_axis: tuser holds the opcode, tdata the value and the
// position. results leave on m_axis: tuser holds the status, tdata the value
// and the position, tlast marks the final result of a request. the capacity
// limit is written through i_cfg_we / i_cfg_wdata; the user must do so only
// while the block is idle; the block itself does not enforce it. a request goes
// into a two-entry command queue, so s_axis_tready stays high until two requests
// wait behind the one the back end is working on. push, failed pop/read and
// empty search/show: the queue hands the request on, the back end takes and
// decides it and the result is registered. pop and read add the registered
// memory read. show reads the top entry, then gives one entry per cycle top
// down while m_axis does not stall. search walks the stack top down at one
// entry per cycle and holds each match until the next one shows it is not
// last. requests run one at a time. a stall on m_axis holds the back end once
// it has a result to give, but a search walk goes on past entries that do not
// match; nothing is dropped. reset empties the stack and sets the capacity
// limit to 64; entry contents are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_stack_with_search_top #(
    parameter int DEPTH      = bsws_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bsws_pkg::DATA_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bsws_pkg::CAP_W-1:0]      i_cfg_wdata,    // capacity_limit
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bsws_pkg::TDATA_W-1:0]    s_axis_tdata,   // data_value, position, pad
    input  logic [bsws_pkg::OP_W-1:0]       s_axis_tuser,   // opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bsws_pkg::TDATA_W-1:0]    m_axis_tdata,   // result_value, result_position, pad
    output logic [bsws_pkg::ST_W-1:0]       m_axis_tuser,   // status
    output logic                            m_axis_tlast
);
    import bsws_pkg::*;

    logic [CAP_W-1:0]    r_cap;
    logic                fr_valid, fr_ready;
    t_cmd                fr_cmd;
    logic                q_valid, q_ready;
    t_cmd                q_cmd;
    t_status             bk_status;
    logic [FIELD_W-1:0]  bk_value;
    logic [POS_W-1:0]    bk_pos;
    t_bk_stat            bk_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    bsws_front u_front (
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_data      (s_axis_tdata[FIELD_W-1:0]),
        .i_pos       (s_axis_tdata[FIELD_W+POS_W-1:FIELD_W]),
        .o_cmd_valid (fr_valid),
        .i_cmd_ready (fr_ready),
        .o_cmd       (fr_cmd)
    );

    bsws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_cmd   (fr_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    bsws_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (r_cap),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (bk_status),
        .o_value     (bk_value),
        .o_pos       (bk_pos),
        .o_last      (m_axis_tlast),
        .o_stat      (bk_stat)
    );

    assign m_axis_tuser = bk_status;
    assign m_axis_tdata = {{(TDATA_W - FIELD_W - POS_W){1'b0}}, bk_pos, bk_value};

    `BSWS_ASSERT(a_count_bound, bk_stat.count <= CAP_W'(DEPTH), "entry count above depth")
    `BSWS_ASSERT_NEXT(a_stall_holds_count, m_axis_tvalid && !m_axis_tready, $stable(bk_stat.count), "count moved while result stalled")
    `BSWS_ASSERT(a_count_moves_busy, ($past(i_rst_n) && bk_stat.count != $past(bk_stat.count)) |-> $past(bk_stat.busy), "count moved while idle")
    `BSWS_ASSERT(a_error_is_last, (m_axis_tvalid && m_axis_tuser != ST_OK) |-> m_axis_tlast, "error result without last")

endmodule

>>> bench/bounded_stack_with_search_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top_tb
// self-checking bench for the bounded stack with search
// ----------------------------------------------------------------------------
// requests go in on s_axis and a local stack predictor works out the replies
// of every request taken. each reply leaving m_axis is checked field by field
// against the oldest predicted one. directed tests cover the empty, full,
// bad position and not found cases and the capacity limit, then random
// phases run under several capacity settings with sender gaps, receiver
// stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_top_tb;
    import bsws_pkg::*;

    localparam int                PAD_W          = TDATA_W - FIELD_W - POS_W;
    localparam int                SETTLE_CYCLES  = 20;
    localparam int                WATCHDOG_LIMIT = 4000;
    localparam int                HOLD_CYCLES    = 300;
    localparam int                PHASE_ITEMS    = 9;
    localparam logic [OP_W-1:0]   OP_UNUSED_LO   = 3'd5;
    localparam logic [OP_W-1:0]   OP_UNUSED_HI   = 3'd7;

    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] value;
        logic [POS_W-1:0]   pos;
        logic               last;
    } t_stack_reply;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CAP_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata  = '0;   // data_value, position, pad
    logic [OP_W-1:0]      s_axis_tuser  = '0;   // opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;         // result_value, result_position, pad
    logic [ST_W-1:0]      m_axis_tuser;         // status
    logic                 m_axis_tlast;

    // predictor state
    logic [FIELD_W-1:0]   model_mem [DEPTH_DEF];
    int                   model_count = 0;
    logic [CAP_W-1:0]     cap_limit   = CAP_RESET;
    t_stack_reply         awaited_replies [$];

    int                   error_count      = 0;
    int                   quiet_cycles     = 0;
    bit                   sender_gaps      = 1'b0;
    bit                   sink_stalls      = 1'b0;
    int                   sink_hold_cycles = 0;
    int                   burst_left       = 0;

    bounded_stack_with_search_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void add_reply(input t_status st, input logic [FIELD_W-1:0] val,
                                      input logic [POS_W-1:0] pos, input logic last);
        t_stack_reply r;
        r.status = st;
        r.value  = val;
        r.pos    = pos;
        r.last   = last;
        awaited_replies.push_back(r);
    endfunction

    // expected replies of one request, and the stack update it makes
    function automatic void predict_stack_op(input logic [OP_W-1:0] op,
                                             input logic [FIELD_W-1:0] val,
                                             input logic [POS_W-1:0] pos);
        int cap;
        int idx;
        int hits;
        cap  = (cap_limit < DEPTH_DEF) ? int'(cap_limit) : DEPTH_DEF;
        hits = 0;
        case (op)
            OP_PUSH: begin
                if (model_count >= cap) begin
                    add_reply(ST_FULL, val, '0, 1'b1);
                end else begin
                    model_mem[model_count] = val;
                    add_reply(ST_OK, val, POS_W'(model_count), 1'b1);
                    model_count++;
                end
            end
            OP_POP: begin
                if (model_count == 0) begin
                    add_reply(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    model_count--;
                    add_reply(ST_OK, model_mem[model_count], POS_W'(model_count), 1'b1);
                end
            end
            OP_READ: begin
                if (int'(pos) >= model_count)
                    add_reply(ST_BADPOS, '0, pos, 1'b1);
                else
                    add_reply(ST_OK, model_mem[pos], pos, 1'b1);
            end
            OP_SEARCH: begin
                for (idx = 0; idx < model_count; idx++)
                    if (model_mem[idx] == val) hits++;
                if (hits == 0)
                    add_reply(ST_NOTFOUND, val, '0, 1'b1);
                for (idx = model_count - 1; idx >= 0; idx--) begin
                    if (model_mem[idx] == val) begin
                        hits--;
                        add_reply(ST_OK, val, POS_W'(idx), hits == 0);
                    end
                end
            end
            OP_SHOW: begin
                if (model_count == 0)
                    add_reply(ST_EMPTY, '0, '0, 1'b1);
                for (idx = model_count - 1; idx >= 0; idx--)
                    add_reply(ST_OK, model_mem[idx], POS_W'(idx), idx == 0);
            end
            default: ;
        endcase
    endfunction

    // call at a rising edge; returns at the edge that takes the request
    task automatic send_request(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        int  gap;
        bit  taken;
        if (sender_gaps && burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, pos, val};
        s_axis_tuser  <= op;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            if (taken) predict_stack_op(op, val, pos);
            @(posedge i_clk);
        end while (!taken);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_capacity(input int limit);
        wait_drained();
        // ignored opcodes give no reply, so let the back end settle too
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CAP_W'(limit);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_limit = CAP_W'(limit);
    endtask

    function automatic logic [FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3, 4, 5: return FIELD_W'($urandom_range(0, 7)) - 32'd3;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] pick_search_key();
        if (model_count > 0 && $urandom_range(0, 9) < 6)
            return model_mem[$urandom_range(0, model_count - 1)];
        return pick_value();
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if (model_count > 0 && $urandom_range(0, 9) < 7)
            return POS_W'($urandom_range(0, model_count - 1));
        if ($urandom_range(0, 1) == 0)
            return POS_W'(model_count);
        return POS_W'($urandom_range(0, DEPTH_DEF - 1));
    endfunction

    task automatic test_directed_ops();
        logic [OP_W-1:0] op;
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        send_request(OP_POP, '0, '0);
        send_request(OP_SHOW, '0, '0);
        send_request(OP_SEARCH, 32'h0000_0005, '0);
        send_request(OP_READ, '0, 6'd0);
        send_request(OP_PUSH, 32'h7FFF_FFFF, '0);
        send_request(OP_PUSH, 32'h8000_0000, 6'd63);
        send_request(OP_PUSH, 32'h0000_0000, '0);
        send_request(OP_PUSH, 32'hFFFF_FFFF, '0);
        send_request(OP_PUSH, 32'hFFFF_FFFF, '0);
        send_request(OP_READ, '0, 6'd0);
        send_request(OP_READ, '0, 6'd4);
        send_request(OP_READ, '0, 6'd5);
        send_request(OP_READ, 32'hFFFF_FFFF, 6'd63);
        send_request(OP_SEARCH, 32'hFFFF_FFFF, '0);
        send_request(OP_SEARCH, 32'h8000_0000, '0);
        send_request(OP_SEARCH, 32'h0001_2345, '0);
        send_request(OP_SHOW, '0, '0);
        for (op = OP_UNUSED_LO; op <= OP_UNUSED_HI && op >= OP_UNUSED_LO; op++)
            send_request(op, 32'hFFFF_FFFF, 6'd63);
        repeat (6) send_request(OP_POP, '0, '0);
    endtask

    task automatic test_capacity_limit();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        set_capacity(1);
        send_request(OP_PUSH, 32'h0000_0011, '0);
        send_request(OP_PUSH, 32'h0000_0022, '0);
        send_request(OP_READ, '0, 6'd0);
        send_request(OP_POP, '0, '0);
        send_request(OP_POP, '0, '0);
        // a limit of zero rejects every push
        set_capacity(0);
        send_request(OP_PUSH, 32'h8000_0001, '0);
        send_request(OP_SEARCH, 32'h8000_0001, '0);
        send_request(OP_SHOW, '0, '0);
        set_capacity(3);
        repeat (4) send_request(OP_PUSH, pick_value(), '0);
        // limit lowered below the number held
        set_capacity(1);
        send_request(OP_PUSH, 32'h0000_0033, '0);
        send_request(OP_POP, '0, '0);
        send_request(OP_POP, '0, '0);
        send_request(OP_PUSH, 32'h0000_0044, '0);
        send_request(OP_POP, '0, '0);
        send_request(OP_POP, '0, '0);
    endtask

    task automatic test_full_depth();
        sender_gaps = 1'b0;
        sink_stalls = 1'b1;
        // a limit above the depth is cut to the depth
        set_capacity(127);
        while (model_count < DEPTH_DEF) send_request(OP_PUSH, pick_value(), '0);
        send_request(OP_PUSH, 32'h5A5A_5A5A, '0);
        send_request(OP_READ, '0, 6'd63);
        send_request(OP_READ, '0, 6'd0);
        send_request(OP_SHOW, '0, '0);
        send_request(OP_SEARCH, model_mem[10], '0);
        send_request(OP_SEARCH, model_mem[63], '0);
    endtask

    task automatic test_backpressure();
        int k;
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        set_capacity(64);
        sink_hold_cycles = HOLD_CYCLES;
        for (k = 0; k < 12; k++) begin
            if (k % 3 == 0)
                send_request(OP_POP, '0, '0);
            else
                send_request(OP_READ, '0, pick_position());
        end
        wait_drained();
    endtask

    task automatic test_random_phase(input int limit, input int n_items,
                                     input bit gaps, input bit stalls);
        int sent;
        int pick;
        set_capacity(limit);
        sender_gaps = gaps;
        sink_stalls = stalls;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            sent++;
            if (pick < 36) begin
                send_request(OP_PUSH, pick_value(), POS_W'($urandom_range(0, 63)));
            end else if (pick < 56) begin
                send_request(OP_POP, $urandom(), POS_W'($urandom_range(0, 63)));
            end else if (pick < 71) begin
                send_request(OP_READ, $urandom(), pick_position());
            end else if (pick < 86) begin
                send_request(OP_SEARCH, pick_search_key(), POS_W'($urandom_range(0, 63)));
            end else if (pick < 94) begin
                send_request(OP_SHOW, $urandom(), POS_W'($urandom_range(0, 63)));
            end else begin
                // ignored codes do not count toward the phase
                sent--;
                send_request(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom(),
                             POS_W'($urandom_range(0, 63)));
            end
        end
    endtask

    initial begin : sink_pacing
        int run;
        int held;
        run = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                held = sink_hold_cycles;
                sink_hold_cycles = 0;
                m_axis_tready <= 1'b0;
                repeat (held) @(posedge i_clk);
                run = 0;
            end else if (run > 0) begin
                run--;
            end else if (sink_stalls && m_axis_tready) begin
                m_axis_tready <= 1'b0;
                run = $urandom_range(0, 5);
            end else begin
                m_axis_tready <= 1'b1;
                run = $urandom_range(1, 12);
            end
        end
    end

    function automatic void compare_field(input string name, input logic [FIELD_W-1:0] want,
                                          input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // outputs are stable from one rising edge to the next, so sample between
    always @(negedge i_clk) begin : reply_check
        t_stack_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_replies.size() == 0) begin
                $display("%0t: reply with none expected, expected none, actual %0h/%0h/%0h/%0b",
                         $time, m_axis_tuser, m_axis_tdata[FIELD_W-1:0],
                         m_axis_tdata[FIELD_W+POS_W-1:FIELD_W], m_axis_tlast);
                error_count++;
            end else begin
                want = awaited_replies.pop_front();
                compare_field("status", FIELD_W'(want.status), FIELD_W'(m_axis_tuser));
                compare_field("result_value", want.value, m_axis_tdata[FIELD_W-1:0]);
                compare_field("result_position", FIELD_W'(want.pos),
                              FIELD_W'(m_axis_tdata[FIELD_W+POS_W-1:FIELD_W]));
                compare_field("last", FIELD_W'(want.last), FIELD_W'(m_axis_tlast));
            end
        end
    end

    always @(negedge i_clk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or reply moved for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_capacity_limit();
        test_full_depth();
        test_backpressure();
        test_random_phase(64, PHASE_ITEMS, 1'b0, 1'b1);
        test_random_phase(6, PHASE_ITEMS, 1'b1, 1'b1);
        test_random_phase(127, PHASE_ITEMS, 1'b1, 1'b0);
        test_random_phase(1, PHASE_ITEMS, 1'b1, 1'b1);
        test_random_phase($urandom_range(2, 30), PHASE_ITEMS, 1'b0, 1'b0);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
